### rtl/core/ntlv_pkg.sv
package ntlv_pkg;

	// Stream and field sizes
	localparam int MAX_STREAM_BYTES = 4096;
	localparam int POS_W            = $clog2(MAX_STREAM_BYTES + 1);
	localparam int TOT_W            = 12;
	localparam int CAP_W            = 12;
	localparam int MLEN_W           = 12;
	localparam int LEFT_W           = 16;
	localparam int CMP_W            = (POS_W > LEFT_W) ? POS_W : LEFT_W;

	localparam logic [CAP_W-1:0] CAP_RESET = '1;

	// TLV type and length codes
	localparam logic [7:0] TLV_NULL = 8'h00;
	localparam logic [7:0] TLV_NDEF = 8'h03;
	localparam logic [7:0] TLV_TERM = 8'hFE;
	localparam logic [7:0] LEN_LONG = 8'hFF;

	// One input beat as held in the input stage
	typedef struct packed {
		logic [7:0]       data_byte;
		logic             first_byte;
		logic [TOT_W-1:0] total_bytes;
	} in_item_t;

	// One result beat
	typedef struct packed {
		logic [7:0]        message_byte;
		logic              byte_valid;
		logic              done_res;
		logic              status;
		logic [MLEN_W-1:0] message_length;
	} result_t;

endpackage

### rtl/core/ntlv_in_if.sv
interface ntlv_in_if;
	import ntlv_pkg::*;

	logic             valid;
	logic             ready;
	logic [7:0]       data_byte;
	logic             first_byte;
	logic [TOT_W-1:0] total_bytes;

	modport source(output valid, data_byte, first_byte, total_bytes, input ready);
	modport sink(input valid, data_byte, first_byte, total_bytes, output ready);

endinterface

### rtl/core/ntlv_out_if.sv
interface ntlv_out_if;
	import ntlv_pkg::*;

	logic              valid;
	logic              ready;
	logic [7:0]        message_byte;
	logic              byte_valid;
	logic              done_res;
	logic              status;
	logic [MLEN_W-1:0] message_length;

	modport source(output valid, message_byte, byte_valid, done_res, status, message_length,
		input ready);
	modport sink(input valid, message_byte, byte_valid, done_res, status, message_length,
		output ready);

endinterface

### rtl/core/ntlv_cfg_if.sv
interface ntlv_cfg_if;
	import ntlv_pkg::*;

	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity;

	modport source(output valid, capacity, input ready);
	modport sink(input valid, capacity, output ready);

endinterface

### rtl/core/ntlv_in_reg.sv
module ntlv_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	ntlv_in_if.sink             stream,
	input  logic                advance,
	output logic                valid_s1,
	output ntlv_pkg::in_item_t  item_s1
);
	import ntlv_pkg::*;

	// Stage takes a beat when empty or when its current beat moves on
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			item_s1.data_byte   <= stream.data_byte;
			item_s1.first_byte  <= stream.first_byte;
			item_s1.total_bytes <= stream.total_bytes;
		end
	end

endmodule

### rtl/core/ntlv_parser.sv
module ntlv_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  ntlv_pkg::in_item_t            item,
	input  logic [ntlv_pkg::CAP_W-1:0]    capacity,
	output logic                          res_valid,
	output ntlv_pkg::result_t             res
);
	import ntlv_pkg::*;

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_LEN,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_SKIP,
		PH_VALUE
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [POS_W-1:0]    pos_q, pos_n;
	logic [POS_W-1:0]    total_q, total_n;
	logic                is_msg_q, is_msg_n;
	logic [7:0]          len_hi_q, len_hi_n;
	logic [LEFT_W-1:0]   left_q, left_n;
	logic [MLEN_W-1:0]   clip_q, clip_n;
	logic                answered_q, answered_n;

	logic [CMP_W-1:0]    tot_w;
	logic [POS_W-1:0]    pos_inc;
	logic [POS_W-1:0]    remaining;
	logic [CMP_W-1:0]    body_len;
	logic [CMP_W-1:0]    clip_w;
	logic [LEFT_W-1:0]   left_dec;
	logic                active;
	logic                done;
	logic                stat;
	logic [MLEN_W-1:0]   mlen;
	logic                ovalid;
	logic                take_body;

	// Next state and result for the beat in the input stage
	always_comb begin
		phase_n    = phase_q;
		pos_n      = pos_q;
		total_n    = total_q;
		is_msg_n   = is_msg_q;
		len_hi_n   = len_hi_q;
		left_n     = left_q;
		clip_n     = clip_q;
		answered_n = answered_q;
		done       = 1'b0;
		stat       = 1'b0;
		mlen       = '0;
		ovalid     = 1'b0;
		take_body  = 1'b0;
		body_len   = '0;

		// New stream: clear the walk and latch the saturated length
		tot_w = CMP_W'(item.total_bytes);
		if (tot_w == '0) begin
			tot_w = CMP_W'(1);
		end
		if (tot_w > CMP_W'(MAX_STREAM_BYTES)) begin
			tot_w = CMP_W'(MAX_STREAM_BYTES);
		end
		if (item.first_byte) begin
			phase_n    = PH_TYPE;
			pos_n      = '0;
			is_msg_n   = 1'b0;
			len_hi_n   = '0;
			left_n     = '0;
			clip_n     = '0;
			answered_n = 1'b0;
			total_n    = POS_W'(tot_w);
		end

		active    = !answered_n && (pos_n < total_n);
		pos_inc   = pos_n + POS_W'(1);
		remaining = total_n - pos_inc;
		left_dec  = (left_n != '0) ? (left_n - LEFT_W'(1)) : left_n;

		if (active) begin
			pos_n = pos_inc;
			case (phase_n)
				PH_TYPE: begin
					if (item.data_byte == TLV_NULL) begin
						phase_n = PH_TYPE;
					end else if (item.data_byte == TLV_TERM) begin
						done = 1'b1;
					end else begin
						is_msg_n = (item.data_byte == TLV_NDEF);
						phase_n  = PH_LEN;
					end
				end
				PH_LEN: begin
					if (item.data_byte == LEN_LONG) begin
						phase_n = PH_LEN_HI;
					end else begin
						take_body = 1'b1;
						body_len  = CMP_W'(item.data_byte);
					end
				end
				PH_LEN_HI: begin
					len_hi_n = item.data_byte;
					phase_n  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					take_body = 1'b1;
					body_len  = CMP_W'({len_hi_n, item.data_byte});
				end
				PH_SKIP: begin
					left_n = left_dec;
					if (left_dec == '0) begin
						phase_n = PH_TYPE;
					end
				end
				PH_VALUE: begin
					ovalid = 1'b1;
					left_n = left_dec;
					if (left_dec == '0) begin
						done = 1'b1;
						mlen = clip_n;
					end
				end
				default: begin
					phase_n = PH_TYPE;
				end
			endcase
		end

		// Length known: clip and check an NDEF body, or skip any other body
		clip_w = (body_len > CMP_W'(remaining)) ? CMP_W'(remaining) : body_len;
		if (take_body) begin
			if (is_msg_n) begin
				clip_n = clip_w[MLEN_W-1:0];
				if (clip_w > CMP_W'(capacity)) begin
					done = 1'b1;
					stat = 1'b1;
				end else if (clip_w == '0) begin
					done = 1'b1;
				end else begin
					left_n  = clip_w[LEFT_W-1:0];
					phase_n = PH_VALUE;
				end
			end else if (body_len == '0) begin
				phase_n = PH_TYPE;
			end else begin
				left_n  = body_len[LEFT_W-1:0];
				phase_n = PH_SKIP;
			end
		end

		// Stream ran out without an answer: empty message
		if (active && !done && (pos_inc >= total_n)) begin
			done = 1'b1;
			stat = 1'b0;
			mlen = '0;
		end
		if (done) begin
			answered_n = 1'b1;
		end

		res_valid          = active && (ovalid || done);
		res.message_byte   = ovalid ? item.data_byte : 8'h00;
		res.byte_valid     = ovalid;
		res.done_res       = done;
		res.status         = stat;
		res.message_length = mlen;
	end

	// Walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TYPE;
			pos_q      <= '0;
			total_q    <= '0;
			is_msg_q   <= 1'b0;
			len_hi_q   <= '0;
			left_q     <= '0;
			clip_q     <= '0;
			answered_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_n;
			pos_q      <= pos_n;
			total_q    <= total_n;
			is_msg_q   <= is_msg_n;
			len_hi_q   <= len_hi_n;
			left_q     <= left_n;
			clip_q     <= clip_n;
			answered_q <= answered_n;
		end
	end

endmodule

### rtl/core/ndef_tlv_stream_extractor.sv
// NDEF TLV stream extractor.
// stream:  one tag data byte per beat; first_byte starts a new stream and
//          total_bytes then gives its length (0 counts as 1).
// message: at most one beat per input byte: a value byte of the first NDEF
//          TLV (byte_valid), and on the last answer beat of a stream done_res
//          with status (1 = over capacity) and message_length.
// setup:   writes the capacity register; always ready. Write it only while
//          the block holds no beat in flight.
// Path:    a taken byte sits in the input stage until its beat advances,
//          and the parse step then loads its result into the output
//          register, which drives message.
// Throughput: one byte per cycle unless a result meets a full, stalled output.
// Reset: clears the walk, the stream length and both stages; capacity
//          returns to 4095. Bytes before the first stream are dropped.
// Stall: while message is held off, the output register keeps its beat and
//          one more byte waits in the input stage; bytes that give no result
//          keep flowing through the parse step.
module ndef_tlv_stream_extractor (
	input  logic       clk,
	input  logic       arst_n,
	ntlv_in_if.sink    stream,
	ntlv_out_if.source message,
	ntlv_cfg_if.sink   setup
);
	import ntlv_pkg::*;

	logic             valid_s1;
	in_item_t         item_s1;
	logic             advance;
	logic             res_valid;
	result_t          res;
	logic [CAP_W-1:0] cap_q;
	logic             out_valid_q;
	result_t          out_q;

	// Capacity register
	assign setup.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (setup.valid) begin
			cap_q <= setup.capacity;
		end
	end

	// Input stage
	ntlv_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Parse step; a beat moves on unless its result would hit a full, stalled output
	assign advance = valid_s1 && (!res_valid || !out_valid_q || message.ready);

	ntlv_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.capacity  (cap_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (message.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign message.valid          = out_valid_q;
	assign message.message_byte   = out_q.message_byte;
	assign message.byte_valid     = out_q.byte_valid;
	assign message.done_res       = out_q.done_res;
	assign message.status         = out_q.status;
	assign message.message_length = out_q.message_length;

endmodule
